/* rtl/neighbor_discovery_scheduler_assert.svh */
// assertion macros used by the neighbor discovery scheduler checker
`ifndef NEIGHBOR_DISCOVERY_SCHEDULER_ASSERT_SVH
`define NEIGHBOR_DISCOVERY_SCHEDULER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define NDS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("neighbor discovery scheduler check failed");

// next-cycle implication, off while reset is low
`define NDS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("neighbor discovery scheduler check failed");

// next-cycle implication that also watches reset itself
`define NDS_ASSERT_RST(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("neighbor discovery scheduler reset check failed");

`endif

/* rtl/nds_pkg.sv */
// types, codes and helpers shared by the neighbor discovery scheduler
package nds_pkg;

    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_TIMER = 2'd1,
        ACT_RX    = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_OWN_ID        = 3'd1,
        CFG_BURST_TX_TOT  = 3'd2,
        CFG_BURST_RX_TOT  = 3'd3,
        CFG_SCAT_TX_TOT   = 3'd4,
        CFG_BURST_TX_GAP  = 3'd5,
        CFG_BURST_RX_WIN  = 3'd6,
        CFG_BURST_RX_SLOT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] own_id;
        logic [7:0]  burst_tx_total;
        logic [7:0]  burst_rx_total;
        logic [15:0] scatter_tx_total;
        logic [15:0] burst_tx_gap;
        logic [15:0] burst_rx_window;
        logic [15:0] burst_rx_slot;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] sender_id;
        logic        length_ok;
        logic        radio_busy;
        logic        tx_collision;
        logic [11:0] jitter_ticks;
    } event_t;

    typedef struct packed {
        logic        radio_on;
        logic        radio_off;
        logic        send_beacon;
        logic        set_timer;
        logic        from_deadline;
        logic [15:0] timer_delay;
        logic        new_neighbor;
        logic [15:0] neighbor_id;
        logic        epoch_end;
        logic [15:0] epoch_number;
        logic [7:0]  epoch_new_count;
    } result_t;

    // a - b, floored at zero
    function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : 16'd0;
    endfunction

    function automatic event_t unpack_event(input logic [S_TDATA_W-1:0] d,
                                            input logic [S_TUSER_W-1:0] u);
        event_t e;
        e.action       = u;
        e.sender_id    = d[15:0];
        e.length_ok    = d[16];
        e.radio_busy   = d[17];
        e.tx_collision = d[18];
        e.jitter_ticks = d[30:19];
        return e;
    endfunction

    function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
        return {1'b0, r.epoch_new_count, r.epoch_number, r.epoch_end, r.neighbor_id,
                r.new_neighbor, r.timer_delay, r.from_deadline, r.set_timer,
                r.send_beacon, r.radio_off, r.radio_on};
    endfunction

    function automatic result_t unpack_result(input logic [M_TDATA_W-1:0] d);
        result_t r;
        r.radio_on        = d[0];
        r.radio_off       = d[1];
        r.send_beacon     = d[2];
        r.set_timer       = d[3];
        r.from_deadline   = d[4];
        r.timer_delay     = d[20:5];
        r.new_neighbor    = d[21];
        r.neighbor_id     = d[37:22];
        r.epoch_end       = d[38];
        r.epoch_number    = d[54:39];
        r.epoch_new_count = d[62:55];
        return r;
    endfunction

endpackage

/* rtl/neighbor_discovery_scheduler.sv */
// top level of the neighbor discovery scheduler: stream ports, config registers, pipeline
//
// Duty-cycled neighbor discovery scheduler. Each event transfer on the s_ side
// (start, timer expired, beacon received) yields exactly one result transfer on
// the m_ side carrying radio on/off/send commands, the next timer request, a
// new-neighbor notice and an epoch-end notice. Events are handled at one per
// clock cycle; an event passes through the input register and then the result
// register before its result is offered on the m_ side. Throughput is set by
// the update of the schedule state in nds_core, so back to back events are
// taken as long as m_tready keeps the result register draining.
// The seen bitmap lives in flip-flops and is cleared by the event that opens a
// new listening round (start, first burst beacon, scatter window), so there is
// no clearing pass after reset. Configuration writes are accepted every cycle
// (cfg_ready is tied high) and should only be issued while no event is in
// flight; mode is sampled at the next start event.
module neighbor_discovery_scheduler
    import nds_pkg::*;
#(
    parameter int MAX_NEIGHBOURS       = 64,
    parameter int SCATTER_WINDOW_TICKS = 4096,
    parameter int SCATTER_SLOT_TICKS   = 512,
    parameter int BUSY_EXTEND_TICKS    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // event channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sender_id[15:0], length_ok[16], radio_busy[17], tx_collision[18],
    // jitter_ticks[30:19], zero[31]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // radio_on[0], radio_off[1], send_beacon[2], set_timer[3], from_deadline[4],
    // timer_delay[20:5], new_neighbor[21], neighbor_id[37:22], epoch_end[38],
    // epoch_number[54:39], epoch_new_count[62:55], zero[63]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    event_t  ev_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t core_res;
    logic    advance;

    // an event moves into the core when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = pack_result(out_reg);

    // configuration registers, written by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode             <= 1'b0;
            cfg_reg.own_id           <= 16'd0;
            cfg_reg.burst_tx_total   <= 8'd1;
            cfg_reg.burst_rx_total   <= 8'd1;
            cfg_reg.scatter_tx_total <= 16'd1;
            cfg_reg.burst_tx_gap     <= 16'd0;
            cfg_reg.burst_rx_window  <= 16'd0;
            cfg_reg.burst_rx_slot    <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:          cfg_reg.mode             <= cfg_data[0];
                CFG_OWN_ID:        cfg_reg.own_id           <= cfg_data;
                CFG_BURST_TX_TOT:  cfg_reg.burst_tx_total   <= cfg_data[7:0];
                CFG_BURST_RX_TOT:  cfg_reg.burst_rx_total   <= cfg_data[7:0];
                CFG_SCAT_TX_TOT:   cfg_reg.scatter_tx_total <= cfg_data;
                CFG_BURST_TX_GAP:  cfg_reg.burst_tx_gap     <= cfg_data;
                CFG_BURST_RX_WIN:  cfg_reg.burst_rx_window  <= cfg_data;
                CFG_BURST_RX_SLOT: cfg_reg.burst_rx_slot    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register: control bit reset, payload only loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ev_reg <= unpack_event(s_tdata, s_tuser);
        end
    end

    // schedule logic and per-epoch state
    nds_core #(
        .MAX_NEIGHBOURS       (MAX_NEIGHBOURS),
        .SCATTER_WINDOW_TICKS (SCATTER_WINDOW_TICKS),
        .SCATTER_SLOT_TICKS   (SCATTER_SLOT_TICKS),
        .BUSY_EXTEND_TICKS    (BUSY_EXTEND_TICKS)
    ) u_nds_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .ev      (ev_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    // result register holds a finished result until the m_ transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_res;
        end
    end

endmodule

/* rtl/nds_core.sv */
// schedule state machine, seen bitmap and per-event result logic
module nds_core
    import nds_pkg::*;
#(
    parameter int MAX_NEIGHBOURS       = 64,
    parameter int SCATTER_WINDOW_TICKS = 4096,
    parameter int SCATTER_SLOT_TICKS   = 512,
    parameter int BUSY_EXTEND_TICKS    = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  event_t  ev,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int          IDX_W    = $clog2(MAX_NEIGHBOURS + 1);
    localparam logic [15:0] MAX_ID   = 16'(MAX_NEIGHBOURS);
    localparam logic [15:0] SCAT_WIN = 16'(SCATTER_WINDOW_TICKS);
    localparam logic [15:0] SCAT_SLT = 16'(SCATTER_SLOT_TICKS);
    localparam logic [15:0] BUSY_EXT = 16'(BUSY_EXTEND_TICKS);

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_BURST_TX  = 6'b000010,
        PH_BURST_RX  = 6'b000100,
        PH_BURST_OFF = 6'b001000,
        PH_SCAT_RX   = 6'b010000,
        PH_SCAT_TX   = 6'b100000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [MAX_NEIGHBOURS:0] seen_reg;
    logic [15:0]         epoch_reg, epoch_next;
    logic [7:0]          found_reg, found_next;
    logic [15:0]         beacons_reg, beacons_next;
    logic [7:0]          windows_reg, windows_next;
    logic                listening_reg, listening_next;
    logic                first_reg, first_next;
    logic                cont_reg, cont_next;

    logic                clear_map, mark;
    logic                do_btx, btx_cont, do_srx;
    logic [7:0]          srx_found;
    logic [15:0]         bs;
    logic [IDX_W-1:0]    idx;
    logic                id_ok, hit;

    assign idx   = ev.sender_id[IDX_W-1:0];
    assign id_ok = (ev.sender_id != 16'd0) && (ev.sender_id <= MAX_ID)
                   && (ev.sender_id != cfg.own_id);
    assign hit   = listening_reg && ev.length_ok && id_ok && !seen_reg[idx];

    always_comb begin
        phase_next     = phase_reg;
        epoch_next     = epoch_reg;
        found_next     = found_reg;
        beacons_next   = beacons_reg;
        windows_next   = windows_reg;
        listening_next = listening_reg;
        first_next     = first_reg;
        cont_next      = cont_reg;
        clear_map      = 1'b0;
        mark           = 1'b0;
        do_btx         = 1'b0;
        btx_cont       = 1'b0;
        do_srx         = 1'b0;
        srx_found      = 8'd0;
        bs             = 16'd0;
        res            = '0;
        res.epoch_number = epoch_reg;

        case (ev.action)
            ACT_START: begin
                clear_map    = 1'b1;
                found_next   = 8'd0;
                beacons_next = 16'd0;
                windows_next = 8'd0;
                if (!cfg.mode) begin
                    cont_next = 1'b0;
                    do_btx    = 1'b1;
                end else begin
                    do_srx = 1'b1;
                end
            end
            ACT_TIMER: begin
                case (phase_reg)
                    PH_BURST_TX: begin
                        do_btx   = 1'b1;
                        btx_cont = cont_reg;
                    end
                    PH_BURST_RX: begin
                        listening_next  = 1'b1;
                        res.radio_on    = 1'b1;
                        res.set_timer   = 1'b1;
                        res.timer_delay = cfg.burst_rx_window;
                        phase_next      = PH_BURST_OFF;
                    end
                    PH_BURST_OFF: begin
                        res.set_timer = 1'b1;
                        if (ev.radio_busy) begin
                            // frame in flight: keep the window open a little longer
                            res.timer_delay = BUSY_EXT;
                        end else begin
                            listening_next    = 1'b0;
                            res.radio_off     = 1'b1;
                            res.from_deadline = 1'b1;
                            res.timer_delay   = sat_sub16(cfg.burst_rx_slot,
                                                          cfg.burst_rx_window);
                            if (({1'b0, windows_reg} + 9'd1) < {1'b0, cfg.burst_rx_total}) begin
                                windows_next = windows_reg + 8'd1;
                                phase_next   = PH_BURST_RX;
                            end else begin
                                res.epoch_end       = 1'b1;
                                res.epoch_new_count = found_reg;
                                epoch_next          = epoch_reg + 16'd1;
                                windows_next        = 8'd0;
                                cont_next           = 1'b0;
                                phase_next          = PH_BURST_TX;
                            end
                        end
                    end
                    PH_SCAT_RX: begin
                        do_srx    = 1'b1;
                        srx_found = found_reg;
                    end
                    PH_SCAT_TX: begin
                        listening_next    = 1'b0;
                        res.radio_off     = 1'b1;
                        res.send_beacon   = 1'b1;
                        res.set_timer     = 1'b1;
                        res.from_deadline = 1'b1;
                        if (ev.tx_collision) begin
                            res.timer_delay = sat_sub16(SCAT_SLT, {4'd0, ev.jitter_ticks});
                        end else begin
                            res.timer_delay = SCAT_SLT;
                            if (({1'b0, beacons_reg} + 17'd1) < {1'b0, cfg.scatter_tx_total}) begin
                                beacons_next = beacons_reg + 16'd1;
                            end else begin
                                phase_next = PH_SCAT_RX;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_RX: begin
                if (hit) begin
                    mark             = 1'b1;
                    res.new_neighbor = 1'b1;
                    res.neighbor_id  = ev.sender_id;
                    found_next       = found_reg + 8'd1;
                end
            end
            default: begin
            end
        endcase

        // burst beacon step, shared by start and the burst transmit timer
        if (do_btx) begin
            listening_next = 1'b0;
            bs = btx_cont ? beacons_reg : 16'd0;
            if (!btx_cont) begin
                clear_map  = 1'b1;
                found_next = 8'd0;
            end
            if (bs < {8'd0, cfg.burst_tx_total}) begin
                res.send_beacon = 1'b1;
                res.set_timer   = 1'b1;
                res.timer_delay = sat_sub16(cfg.burst_tx_gap, {4'd0, ev.jitter_ticks});
                beacons_next    = bs + 16'd1;
                cont_next       = 1'b1;
                phase_next      = PH_BURST_TX;
            end else begin
                beacons_next    = bs;
                listening_next  = 1'b1;
                res.radio_on    = 1'b1;
                res.set_timer   = 1'b1;
                res.timer_delay = cfg.burst_rx_window;
                phase_next      = PH_BURST_OFF;
            end
        end

        // scatter window opening, which also closes the previous epoch unless it is the first window
        if (do_srx) begin
            if (!first_reg) begin
                res.epoch_end       = 1'b1;
                res.epoch_new_count = srx_found;
                epoch_next          = epoch_reg + 16'd1;
                beacons_next        = 16'd0;
            end
            first_next      = 1'b0;
            clear_map       = 1'b1;
            found_next      = 8'd0;
            listening_next  = 1'b1;
            res.radio_on    = 1'b1;
            res.set_timer   = 1'b1;
            res.timer_delay = SCAT_WIN;
            phase_next      = PH_SCAT_TX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            seen_reg      <= '0;
            epoch_reg     <= 16'd0;
            found_reg     <= 8'd0;
            beacons_reg   <= 16'd0;
            windows_reg   <= 8'd0;
            listening_reg <= 1'b0;
            first_reg     <= 1'b1;
            cont_reg      <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            epoch_reg     <= epoch_next;
            found_reg     <= found_next;
            beacons_reg   <= beacons_next;
            windows_reg   <= windows_next;
            listening_reg <= listening_next;
            first_reg     <= first_next;
            cont_reg      <= cont_next;
            if (clear_map) begin
                seen_reg <= '0;
            end else if (mark) begin
                seen_reg[idx] <= 1'b1;
            end
        end
    end

endmodule

/* rtl/nds_checker.sv */
// port-level checks on the neighbor discovery scheduler and their bind
`include "neighbor_discovery_scheduler_assert.svh"

module nds_checker
    import nds_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    result_t m_res;

    assign m_res = unpack_result(m_tdata);

    // result register comes out of reset empty
    `NDS_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // a stalled result transfer keeps its contents
    `NDS_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata))

    // timer fields are zero unless a timer is requested
    `NDS_ASSERT_IMP(a_timer_clean, aclk, aresetn, m_tvalid && !m_res.set_timer,
                    (m_res.timer_delay == 16'd0) && !m_res.from_deadline)

    // a neighbor notice comes from a beacon event only and carries a real id
    `NDS_ASSERT_IMP(a_neighbor_alone, aclk, aresetn, m_tvalid && m_res.new_neighbor,
                    !m_res.radio_on && !m_res.radio_off && !m_res.set_timer
                    && !m_res.epoch_end && (m_res.neighbor_id != 16'd0))

    // epoch summary fields stay clear without an epoch end
    `NDS_ASSERT_IMP(a_epoch_clean, aclk, aresetn, m_tvalid && !m_res.epoch_end,
                    m_res.epoch_new_count == 8'd0)

endmodule

bind neighbor_discovery_scheduler nds_checker u_nds_checker (.*);
